[rtl/packet_buffer_refcount_allocator_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros used by the allocator core.
// Assertions use the module's clock and reset signals.
// ---------------------------------------------------------------------------
`ifndef PACKET_BUFFER_REFCOUNT_ALLOCATOR_DEFINES_SVH
`define PACKET_BUFFER_REFCOUNT_ALLOCATOR_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define PBRA_ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// A condition that, once seen, must be followed by another in the next cycle.
`define PBRA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/pbra_pkg.sv]
// ---------------------------------------------------------------------------
// pbra_pkg
// Constants, codes and types of the packet/buffer allocator.
// ---------------------------------------------------------------------------
`default_nettype none

package pbra_pkg;

   localparam int NUM_PACKETS = 1024;
   localparam int NUM_BUFFERS = 1024;

   // Width of every packet or buffer index and count on the ports.
   localparam int FIELD_W = 11;
   localparam int PKT_AW  = $clog2(NUM_PACKETS);
   localparam int BUF_AW  = $clog2(NUM_BUFFERS);

   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_FREE  = 2'd1;
   localparam logic [1:0] OP_CLONE = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NOSPACE = 2'd1;
   localparam logic [1:0] ST_BADPKT  = 2'd2;

   typedef struct packed {
      logic [FIELD_W-1:0] result_pkt;
      logic [FIELD_W-1:0] result_buf;
      logic [1:0]         status;
      logic [FIELD_W-1:0] pkts_in_use;
      logic [FIELD_W-1:0] bufs_in_use;
   } result_type;

endpackage

`default_nettype wire

[rtl/pbra_ram.sv]
// ---------------------------------------------------------------------------
// pbra_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module pbra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

[rtl/pbra_core.sv]
// ---------------------------------------------------------------------------
// pbra_core
// Sequencer over the two free stacks, the packet map and the reference counts.
// ---------------------------------------------------------------------------
`default_nettype none
`include "packet_buffer_refcount_allocator_defines.svh"

module pbra_core
   import pbra_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [1:0]         op,
   input  wire logic [FIELD_W-1:0] pkt,
   input  wire logic               slot_free,
   output logic                    idle,
   output logic                    done,
   output result_type              result
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   localparam logic [FIELD_W-1:0] NPKT = FIELD_W'(NUM_PACKETS);
   localparam logic [FIELD_W-1:0] NBUF = FIELD_W'(NUM_BUFFERS);
   localparam logic [FIELD_W-1:0] ONE  = FIELD_W'(1);

   logic [1:0]         state_ff, state_in;
   logic [1:0]         op_ff;
   logic [FIELD_W-1:0] pkt_ff;
   logic [FIELD_W-1:0] pcount_ff, pcount_in;
   logic [FIELD_W-1:0] bcount_ff, bcount_in;
   // Low-water marks: stack entries below them were never written, so their
   // values are computed from the index instead of read.
   logic [FIELD_W-1:0] plow_ff, plow_in;
   logic [FIELD_W-1:0] blow_ff, blow_in;
   logic [FIELD_W-1:0] np_ff, np_in;
   logic [FIELD_W-1:0] nb_ff, nb_in;
   logic [FIELD_W-1:0] bufi_ff, bufi_in;
   logic               pok_ff, pok_in;

   logic [FIELD_W-1:0] pstack_q, bstack_q, map_q, ref_q;
   logic [FIELD_W-1:0] req_pkt_m1, pcount_m1, bcount_m1, mapped, mapped_m1, bufi_m1;
   logic [FIELD_W-1:0] ref_rd_idx, cnt, cnt_new;
   logic [FIELD_W-1:0] np_m1, nb_m1, pkt_m1;
   logic               fire;

   logic               map_we, ref_we, pstack_we, bstack_we;
   logic [PKT_AW-1:0]  map_wa, pstack_wa;
   logic [BUF_AW-1:0]  ref_wa, bstack_wa;
   logic [FIELD_W-1:0] map_wd, ref_wd;

   assign req_pkt_m1 = pkt - ONE;
   assign pcount_m1  = pcount_ff - ONE;
   assign bcount_m1  = bcount_ff - ONE;
   assign pkt_m1     = pkt_ff - ONE;
   assign np_m1      = np_ff - ONE;
   assign nb_m1      = nb_ff - ONE;
   assign bufi_m1    = bufi_ff - ONE;

   // Packets above NUM_PACKETS minus the low mark were never handed out, so
   // their map entries were never written and read as unused.
   assign mapped    = (pkt_ff <= NPKT - plow_ff) ? map_q : '0;
   assign mapped_m1 = mapped - ONE;
   assign ref_rd_idx = (state_ff == ST_READ) ? mapped_m1 : bufi_m1;
   assign cnt       = (bufi_ff <= NBUF - blow_ff) ? ref_q : '0;
   assign cnt_new   = (cnt != '0) ? cnt - ONE : '0;

   assign idle = (state_ff == ST_IDLE);
   assign fire = (state_ff == ST_DONE) && slot_free;
   assign done = fire;

   pbra_ram #(.WIDTH(FIELD_W), .DEPTH(NUM_PACKETS)) u_pstack (
      .clock(clock), .wr_en(pstack_we), .wr_addr(pstack_wa), .wr_data(pkt_ff),
      .rd_addr(pcount_m1[PKT_AW-1:0]), .rd_data(pstack_q)
   );

   pbra_ram #(.WIDTH(FIELD_W), .DEPTH(NUM_BUFFERS)) u_bstack (
      .clock(clock), .wr_en(bstack_we), .wr_addr(bstack_wa), .wr_data(bufi_ff),
      .rd_addr(bcount_m1[BUF_AW-1:0]), .rd_data(bstack_q)
   );

   pbra_ram #(.WIDTH(FIELD_W), .DEPTH(NUM_PACKETS)) u_map (
      .clock(clock), .wr_en(map_we), .wr_addr(map_wa), .wr_data(map_wd),
      .rd_addr(req_pkt_m1[PKT_AW-1:0]), .rd_data(map_q)
   );

   pbra_ram #(.WIDTH(FIELD_W), .DEPTH(NUM_BUFFERS)) u_refcnt (
      .clock(clock), .wr_en(ref_we), .wr_addr(ref_wa), .wr_data(ref_wd),
      .rd_addr(ref_rd_idx[BUF_AW-1:0]), .rd_data(ref_q)
   );

   always_comb begin
      state_in  = state_ff;
      pcount_in = pcount_ff;
      bcount_in = bcount_ff;
      plow_in   = plow_ff;
      blow_in   = blow_ff;
      np_in     = np_ff;
      nb_in     = nb_ff;
      bufi_in   = bufi_ff;
      pok_in    = pok_ff;
      map_we    = 1'b0;
      ref_we    = 1'b0;
      pstack_we = 1'b0;
      bstack_we = 1'b0;
      map_wa    = np_m1[PKT_AW-1:0];
      map_wd    = nb_ff;
      ref_wa    = nb_m1[BUF_AW-1:0];
      ref_wd    = ONE;
      pstack_wa = pcount_ff[PKT_AW-1:0];
      bstack_wa = bcount_ff[BUF_AW-1:0];
      result.result_pkt = '0;
      result.result_buf = '0;
      result.status     = ST_BADPKT;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            // Stack and map data for the item are now on the read ports.
            np_in   = (pcount_ff > plow_ff) ? pstack_q : NPKT - pcount_ff + ONE;
            nb_in   = (bcount_ff > blow_ff) ? bstack_q : NBUF - bcount_ff + ONE;
            bufi_in = mapped;
            pok_in  = (pkt_ff >= ONE) && (pkt_ff <= NPKT) && (mapped != '0);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            case (op_ff)
               OP_ALLOC: begin
                  if (pcount_ff == '0 || bcount_ff == '0) begin
                     result.status = ST_NOSPACE;
                  end else begin
                     result.status     = ST_OK;
                     result.result_pkt = np_ff;
                     result.result_buf = nb_ff;
                     map_we    = fire;
                     ref_we    = fire;
                     pcount_in = pcount_m1;
                     bcount_in = bcount_m1;
                  end
               end
               OP_FREE: begin
                  if (pok_ff && pcount_ff < NPKT) begin
                     result.status     = ST_OK;
                     result.result_buf = bufi_ff;
                     map_we    = fire;
                     map_wa    = pkt_m1[PKT_AW-1:0];
                     map_wd    = '0;
                     pstack_we = fire;
                     pcount_in = pcount_ff + ONE;
                     if (bufi_ff <= NBUF) begin
                        ref_we = fire;
                        ref_wa = bufi_m1[BUF_AW-1:0];
                        ref_wd = cnt_new;
                        if (cnt_new == '0 && bcount_ff < NBUF) begin
                           bstack_we = fire;
                           bcount_in = bcount_ff + ONE;
                        end
                     end
                  end
               end
               OP_CLONE: begin
                  if (!pok_ff) begin
                     result.status = ST_BADPKT;
                  end else if (pcount_ff == '0) begin
                     result.status = ST_NOSPACE;
                  end else begin
                     result.status     = ST_OK;
                     result.result_pkt = np_ff;
                     result.result_buf = bufi_ff;
                     map_we    = fire;
                     map_wd    = bufi_ff;
                     ref_we    = fire && (bufi_ff <= NBUF);
                     ref_wa    = bufi_m1[BUF_AW-1:0];
                     ref_wd    = cnt + ONE;
                     pcount_in = pcount_m1;
                  end
               end
               default: begin
                  result.status = ST_BADPKT;
               end
            endcase
            if (pcount_in < plow_ff) begin
               plow_in = pcount_in;
            end
            if (bcount_in < blow_ff) begin
               blow_in = bcount_in;
            end
            if (!fire) begin
               pcount_in = pcount_ff;
               bcount_in = bcount_ff;
               plow_in   = plow_ff;
               blow_in   = blow_ff;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      result.pkts_in_use = NPKT - pcount_in;
      result.bufs_in_use = NBUF - bcount_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         pcount_ff <= NPKT;
         bcount_ff <= NBUF;
         plow_ff   <= NPKT;
         blow_ff   <= NBUF;
      end else begin
         state_ff  <= state_in;
         pcount_ff <= pcount_in;
         bcount_ff <= bcount_in;
         plow_ff   <= plow_in;
         blow_ff   <= blow_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start && idle) begin
         op_ff  <= op;
         pkt_ff <= pkt;
      end
      np_ff   <= np_in;
      nb_ff   <= nb_in;
      bufi_ff <= bufi_in;
      pok_ff  <= pok_in;
   end

   `PBRA_ASSERT_ALWAYS(a_pkt_count, pcount_ff <= NPKT && plow_ff <= pcount_ff,
      "packet free count or low mark out of range")
   `PBRA_ASSERT_ALWAYS(a_buf_count, bcount_ff <= NBUF && blow_ff <= bcount_ff,
      "buffer free count or low mark out of range")
   `PBRA_ASSERT_ALWAYS(a_share, NPKT - pcount_ff >= NBUF - bcount_ff,
      "more buffers in use than packets")
   `PBRA_ASSERT_NEXT(a_start, start && idle, state_ff == ST_READ,
      "accepted item did not start its memory reads")
   `PBRA_ASSERT_NEXT(a_stall, state_ff == ST_DONE && !slot_free,
      state_ff == ST_DONE && $stable(pcount_ff) && $stable(bcount_ff),
      "state changed while the result was stalled")

endmodule

`default_nettype wire

[rtl/packet_buffer_refcount_allocator.sv]
// ---------------------------------------------------------------------------
// packet_buffer_refcount_allocator
// Allocates packets and shared data buffers with per-buffer reference counts.
// ---------------------------------------------------------------------------
// Usage:
// An item on the req_ channel carries an operation (alloc, free or clone) and
// a packet index. Each item yields exactly one item on the rsp_ channel with
// the packet and buffer handled, a status code and the packet and buffer
// occupancy after the operation.
// From acceptance, the block reads the packet map and both free stack tops,
// then reads the reference count of the mapped buffer, and last writes back
// and loads the output register. One item is in flight at a time: a new item
// is accepted only once the last one is written back, so the dependent map
// then reference-count read sets the pace.
// The next item may be accepted while a result still waits in the output
// register. If rsp_ready stays low, the finished write-back waits until the
// output register is free, and req_ready stays low meanwhile.
// Reset makes both free stacks full and every packet unused; it takes effect
// at once, with no clearing pass over the memories.
// ---------------------------------------------------------------------------
`default_nettype none

module packet_buffer_refcount_allocator
   import pbra_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_op,
   input  wire logic [FIELD_W-1:0] req_pkt,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic      [FIELD_W-1:0] rsp_result_pkt,
   output logic      [FIELD_W-1:0] rsp_result_buf,
   output logic      [1:0]         rsp_status,
   output logic      [FIELD_W-1:0] rsp_pkts_in_use,
   output logic      [FIELD_W-1:0] rsp_bufs_in_use
);

   logic       core_idle, core_done, slot_free;
   result_type core_result;
   result_type rsp_ff;
   logic       rsp_valid_ff;

   assign req_ready = core_idle;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   pbra_core u_core (
      .clock     (clock),
      .reset     (reset),
      .start     (req_valid && core_idle),
      .op        (req_op),
      .pkt       (req_pkt),
      .slot_free (slot_free),
      .idle      (core_idle),
      .done      (core_done),
      .result    (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (core_done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (core_done) begin
         rsp_ff <= core_result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_pkt  = rsp_ff.result_pkt;
   assign rsp_result_buf  = rsp_ff.result_buf;
   assign rsp_status      = rsp_ff.status;
   assign rsp_pkts_in_use = rsp_ff.pkts_in_use;
   assign rsp_bufs_in_use = rsp_ff.bufs_in_use;

endmodule

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the packet/buffer allocator with reference counts.
// A shadow allocator keeps its own free stacks, packet map and buffer counts
// and computes the response for every request as it is queued. The driver
// offers queued requests and the monitor compares responses in order.
// Traffic runs through directed corner cases and then phases that fill the
// allocator past exhaustion and drain it again, under changing back-pressure.
// ---------------------------------------------------------------------------

module tb_top;
   import pbra_pkg::*;

   localparam logic [1:0] OP_UNDEF    = 2'd3;
   localparam int         CYCLE_LIMIT = 400000;
   localparam int         LONG_HOLD   = 400;

   typedef struct packed {
      logic [1:0]         op;
      logic [FIELD_W-1:0] pkt;
      result_type         want;
   } alloc_request_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_op = OP_ALLOC;
   logic [FIELD_W-1:0] req_pkt = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [FIELD_W-1:0] rsp_result_pkt;
   logic [FIELD_W-1:0] rsp_result_buf;
   logic [1:0]         rsp_status;
   logic [FIELD_W-1:0] rsp_pkts_in_use;
   logic [FIELD_W-1:0] rsp_bufs_in_use;

   packet_buffer_refcount_allocator u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_pkt         (req_pkt),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_pkt  (rsp_result_pkt),
      .rsp_result_buf  (rsp_result_buf),
      .rsp_status      (rsp_status),
      .rsp_pkts_in_use (rsp_pkts_in_use),
      .rsp_bufs_in_use (rsp_bufs_in_use)
   );

   always #6 clock = ~clock;

   // Shadow allocator state.
   logic [FIELD_W-1:0] shadow_pkt_stack [NUM_PACKETS];
   logic [FIELD_W-1:0] shadow_buf_stack [NUM_BUFFERS];
   logic [FIELD_W-1:0] shadow_pkt_map   [NUM_PACKETS+1];
   logic [FIELD_W-1:0] shadow_buf_refs  [NUM_BUFFERS+1];
   int                 shadow_pkt_free;
   int                 shadow_buf_free;

   alloc_request_type  pending_requests [$];
   result_type         awaiting_responses [$];
   logic [FIELD_W-1:0] live_pkts [$];
   alloc_request_type  offered;

   int send_idle_pct = 32;
   int recv_idle_pct = 60;
   int error_count = 0;
   int cycle_count = 0;
   int responses_seen = 0;
   int ok_count = 0;
   int nospace_count = 0;
   int rejected_count = 0;
   int peak_pkts = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;

   // Applies one request to the shadow allocator and returns its response.
   function automatic result_type allocate_step(logic [1:0] op, logic [FIELD_W-1:0] pkt);
      result_type         r;
      logic [FIELD_W-1:0] np;
      logic [FIELD_W-1:0] b;
      bit                 in_use;
      r = '0;
      in_use = 1'b0;
      if (pkt >= 1 && pkt <= NUM_PACKETS)
         in_use = (shadow_pkt_map[pkt] != 0);
      case (op)
         OP_ALLOC: begin
            if (shadow_pkt_free == 0 || shadow_buf_free == 0) begin
               r.status = ST_NOSPACE;
            end else begin
               shadow_pkt_free--;
               shadow_buf_free--;
               np = shadow_pkt_stack[shadow_pkt_free];
               b  = shadow_buf_stack[shadow_buf_free];
               shadow_pkt_map[np] = b;
               shadow_buf_refs[b] = FIELD_W'(1);
               r.result_pkt = np;
               r.result_buf = b;
               r.status     = ST_OK;
            end
         end
         OP_FREE: begin
            if (!in_use || shadow_pkt_free >= NUM_PACKETS) begin
               r.status = ST_BADPKT;
            end else begin
               b = shadow_pkt_map[pkt];
               shadow_pkt_map[pkt] = '0;
               shadow_pkt_stack[shadow_pkt_free] = pkt;
               shadow_pkt_free++;
               if (shadow_buf_refs[b] != 0)
                  shadow_buf_refs[b]--;
               // The buffer goes back only when its last packet is gone.
               if (shadow_buf_refs[b] == 0 && shadow_buf_free < NUM_BUFFERS) begin
                  shadow_buf_stack[shadow_buf_free] = b;
                  shadow_buf_free++;
               end
               r.result_buf = b;
               r.status     = ST_OK;
            end
         end
         OP_CLONE: begin
            if (!in_use) begin
               r.status = ST_BADPKT;
            end else if (shadow_pkt_free == 0) begin
               r.status = ST_NOSPACE;
            end else begin
               b = shadow_pkt_map[pkt];
               shadow_pkt_free--;
               np = shadow_pkt_stack[shadow_pkt_free];
               shadow_buf_refs[b]++;
               shadow_pkt_map[np] = b;
               r.result_pkt = np;
               r.result_buf = b;
               r.status     = ST_OK;
            end
         end
         default: r.status = ST_BADPKT;
      endcase
      r.pkts_in_use = FIELD_W'(NUM_PACKETS - shadow_pkt_free);
      r.bufs_in_use = FIELD_W'(NUM_BUFFERS - shadow_buf_free);
      return r;
   endfunction

   // Predicts a request, queues it for the driver and tracks live packets.
   task automatic issue(logic [1:0] op, logic [FIELD_W-1:0] pkt);
      alloc_request_type rq;
      rq.op   = op;
      rq.pkt  = pkt;
      rq.want = allocate_step(op, pkt);
      pending_requests.push_back(rq);
      if (rq.want.status == ST_OK) begin
         if (op == OP_FREE) begin
            for (int i = 0; i < live_pkts.size(); i++) begin
               if (live_pkts[i] == pkt) begin
                  live_pkts.delete(i);
                  break;
               end
            end
         end else begin
            live_pkts.push_back(rq.want.result_pkt);
         end
      end
   endtask

   task automatic random_request(int alloc_pct, int clone_pct, int free_pct);
      int                 roll;
      logic [FIELD_W-1:0] target;
      roll = $urandom_range(99);
      if (live_pkts.size() > 0)
         target = live_pkts[$urandom_range(live_pkts.size() - 1)];
      else
         target = FIELD_W'($urandom_range(NUM_PACKETS));
      if (roll < alloc_pct)
         issue(OP_ALLOC, FIELD_W'($urandom_range(2047)));
      else if (roll < alloc_pct + clone_pct)
         issue(OP_CLONE, target);
      else if (roll < alloc_pct + clone_pct + free_pct)
         issue(OP_FREE, target);
      else if ($urandom_range(1) == 1)
         issue(2'($urandom_range(3)), FIELD_W'($urandom_range(2047)));
      else
         // Likely a stale or never used packet.
         issue($urandom_range(1) == 1 ? OP_FREE : OP_CLONE,
               FIELD_W'($urandom_range(NUM_PACKETS, 1)));
   endtask

   task automatic wait_drained();
      while (pending_requests.size() != 0 || req_valid || awaiting_responses.size() != 0)
         @(negedge clock);
   endtask

   task automatic check_field(string name, logic [FIELD_W-1:0] want, logic [FIELD_W-1:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   // Driver: a new item is offered only once the previous one was taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            awaiting_responses.push_back(offered.want);
         if (!req_valid || req_ready) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               offered = pending_requests.pop_front();
               req_valid <= 1'b1;
               req_op    <= offered.op;
               req_pkt   <= offered.pkt;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks responses in order and drives back-pressure.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            responses_seen++;
            if (awaiting_responses.size() == 0) begin
               $error("response with no request outstanding: pkt %0d buf %0d status %0d",
                      rsp_result_pkt, rsp_result_buf, rsp_status);
               error_count++;
            end else begin
               result_type want;
               want = awaiting_responses.pop_front();
               check_field("result_pkt", want.result_pkt, rsp_result_pkt);
               check_field("result_buf", want.result_buf, rsp_result_buf);
               check_field("status", FIELD_W'(want.status), FIELD_W'(rsp_status));
               check_field("pkts_in_use", want.pkts_in_use, rsp_pkts_in_use);
               check_field("bufs_in_use", want.bufs_in_use, rsp_bufs_in_use);
            end
            case (rsp_status)
               ST_OK:      ok_count++;
               ST_NOSPACE: nospace_count++;
               default:    rejected_count++;
            endcase
            if (rsp_pkts_in_use > peak_pkts)
               peak_pkts = rsp_pkts_in_use;
         end
         // One long hold-off lets the block back up and stall its input.
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!hold_done && responses_seen >= 300) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d responses outstanding",
                  cycle_count, awaiting_responses.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < NUM_PACKETS; i++)
         shadow_pkt_stack[i] = FIELD_W'(NUM_PACKETS - i);
      for (int i = 0; i < NUM_BUFFERS; i++)
         shadow_buf_stack[i] = FIELD_W'(NUM_BUFFERS - i);
      for (int i = 0; i <= NUM_PACKETS; i++)
         shadow_pkt_map[i] = '0;
      for (int i = 0; i <= NUM_BUFFERS; i++)
         shadow_buf_refs[i] = '0;
      shadow_pkt_free = NUM_PACKETS;
      shadow_buf_free = NUM_BUFFERS;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed corner cases: sharing, stale and out-of-range packets,
      // the undefined operation and the extremes of the packet field.
      issue(OP_ALLOC, '0);
      issue(OP_CLONE, FIELD_W'(1));
      issue(OP_CLONE, FIELD_W'(2));
      issue(OP_FREE, FIELD_W'(1));
      issue(OP_FREE, FIELD_W'(1));
      issue(OP_FREE, '0);
      issue(OP_CLONE, '0);
      issue(OP_FREE, FIELD_W'(NUM_PACKETS + 1));
      issue(OP_CLONE, '1);
      issue(OP_UNDEF, FIELD_W'(2));
      issue(OP_UNDEF, '1);
      issue(OP_FREE, FIELD_W'(NUM_PACKETS));
      issue(OP_CLONE, FIELD_W'(NUM_PACKETS));
      issue(OP_FREE, FIELD_W'(2));
      issue(OP_FREE, FIELD_W'(3));
      issue(OP_FREE, FIELD_W'(3));
      issue(OP_ALLOC, '1);
      issue(OP_ALLOC, '0);
      issue(OP_CLONE, live_pkts[0]);
      issue(OP_FREE, live_pkts[1]);
      wait_drained();

      // Fill mostly with allocs and clones; the long hold-off lands here.
      repeat (900) random_request(50, 35, 5);
      wait_drained();

      // Keep filling past exhaustion so both no-space cases show up.
      send_idle_pct = 60;
      recv_idle_pct = 32;
      repeat (400) random_request(45, 40, 5);
      wait_drained();

      // Drain with full throughput on both sides.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (650) random_request(8, 7, 70);
      wait_drained();

      repeat (20) @(negedge clock);
      $display("Checked %0d responses: %0d ok, %0d out of space, %0d rejected.",
               responses_seen, ok_count, nospace_count, rejected_count);
      $display("Peak of %0d packets in use, reached over fill and drain phases.", peak_pkts);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
